[sv/rmf_pkg.sv]
// Shared constants and types for the running median filter.
package rmf_pkg;

   localparam int MAX_WINDOW_DEF = 16;
   localparam int SAMPLE_W       = 16;
   localparam int COUNT_W        = 5;

   localparam logic [COUNT_W-1:0] WINDOW_SIZE_RESET = COUNT_W'(5);

   // Write controls for the sorted list.
   typedef struct packed {
      logic wr_en;
      logic wr_key;
   } rmf_sort_ctrl_type;

   // Result of the shared compare unit: stored entry versus key.
   typedef struct packed {
      logic gt;
      logic eq;
   } rmf_cmp_type;

endpackage

[sv/rmf_channels_if.sv]
// Handshake interfaces for the request, response and register write channels.
interface rmf_req_if import rmf_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface rmf_rsp_if import rmf_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] median_value;
   logic [COUNT_W-1:0]         fill_count;
   modport source (output valid, output median_value, output fill_count, input ready);
   modport sink (input valid, input median_value, input fill_count, output ready);
endinterface

interface rmf_csr_if import rmf_pkg::*;;
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] window_size;
   modport source (output valid, output window_size, input ready);
   modport sink (input valid, input window_size, output ready);
endinterface

[sv/rmf_sort_store.sv]
// Sorted copy of the window with one read port, one write port and the shared comparator.
module rmf_sort_store import rmf_pkg::*; #(
   parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
   input  logic                                 clock,
   input  logic [$clog2(MAX_WINDOW)-1:0]        rd_idx,
   input  logic [$clog2(MAX_WINDOW)-1:0]        wr_idx,
   input  rmf_sort_ctrl_type                    ctrl,
   input  logic signed [SAMPLE_W-1:0]           key,
   output logic signed [SAMPLE_W-1:0]           rd_data,
   output rmf_cmp_type                          cmp
);

   logic signed [SAMPLE_W-1:0] sorted_ff [MAX_WINDOW];

   assign rd_data = sorted_ff[rd_idx];
   assign cmp.gt  = rd_data > key;
   assign cmp.eq  = rd_data == key;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         sorted_ff[wr_idx] <= ctrl.wr_key ? key : rd_data;
      end
   end

endmodule

[sv/running_median_filter_unit.sv]
// Each request first drops samples as needed (one drop once the window is full), each drop
// a pass over the sorted list, then writes the history slot, inserts the sample by moving the
// larger sorted entries up, and reads the median; an even count reads a second entry.
// One request at a time through the single compare unit: a new request is taken only once
// the previous response is loaded, and a stalled response holds the block until it is taken.
// Reset clears count, write slot and response valid, sets window_size to 5; memories keep data.
module running_median_filter_unit import rmf_pkg::*; #(
   parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
   input  logic       clock,
   input  logic       reset,
   rmf_req_if.sink    req_if,
   rmf_rsp_if.source  rsp_if,
   rmf_csr_if.sink    csr_if
);

   localparam int SW = $clog2(MAX_WINDOW);
   localparam int CW = $clog2(MAX_WINDOW + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_EV_CHECK, S_EV_PASS, S_HIST_WR, S_INS, S_MED_A, S_MED_B, S_FIN
   } state_type;

   state_type                  state_ff;
   logic [COUNT_W-1:0]         window_size_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic [SW-1:0]              last_ff;
   logic [CW-1:0]              len_ff;
   logic [CW-1:0]              evict_ff;
   logic [SW-1:0]              ev_slot_ff;
   logic [SW-1:0]              idx_ff;
   logic                       found_ff;
   logic signed [SAMPLE_W:0]   acc_ff;
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_median_ff;
   logic [COUNT_W-1:0]         rsp_count_ff;

   logic signed [SAMPLE_W-1:0] hist [MAX_WINDOW];
   logic signed [SAMPLE_W-1:0] hist_q_ff;

   logic [CW-1:0]              win;
   logic [CW:0]                cnt_inc;
   logic [CW:0]                new_cnt;
   logic [CW:0]                ev_diff;
   logic [SW-1:0]              ev_start;
   logic [SW-1:0]              med_idx;
   logic [SW-1:0]              med_hi_idx;
   logic [SW-1:0]              rd_idx;
   logic [SW-1:0]              wr_idx;
   logic signed [SAMPLE_W-1:0] key;
   logic signed [SAMPLE_W-1:0] rd_data;
   rmf_sort_ctrl_type          sort_ctrl;
   rmf_cmp_type                cmp;
   logic                       req_accept;

   assign req_if.ready = (state_ff == S_IDLE);
   assign req_accept   = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.median_value = rsp_median_ff;
   assign rsp_if.fill_count   = rsp_count_ff;

   // Window bookkeeping for the request being accepted.
   always_comb begin
      if (window_size_ff == '0) begin
         win = CW'(1);
      end else if (int'(window_size_ff) > MAX_WINDOW) begin
         win = CW'(MAX_WINDOW);
      end else begin
         win = CW'(window_size_ff);
      end
      cnt_inc = {1'b0, len_ff} + (CW+1)'(1);
      new_cnt = (cnt_inc > {1'b0, win}) ? {1'b0, win} : cnt_inc;
      ev_diff = (CW+1)'(last_ff) + (CW+1)'(MAX_WINDOW) - {1'b0, len_ff};
      if (ev_diff >= (CW+1)'(MAX_WINDOW)) begin
         ev_start = SW'(ev_diff - (CW+1)'(MAX_WINDOW));
      end else begin
         ev_start = SW'(ev_diff);
      end
   end

   // The middle pair sits at count/2 - 1 and count/2; an odd count uses count/2 alone.
   assign med_hi_idx = SW'(len_ff >> 1);
   assign med_idx    = len_ff[0] ? med_hi_idx : med_hi_idx - SW'(1);

   always_comb begin
      sort_ctrl = '0;
      rd_idx    = idx_ff;
      wr_idx    = idx_ff;
      key       = sample_ff;
      unique case (state_ff)
         S_EV_PASS: begin
            key    = hist_q_ff;
            rd_idx = idx_ff;
            // Once the departing value is found, every later entry moves down by one.
            wr_idx          = idx_ff - SW'(1);
            sort_ctrl.wr_en = found_ff;
         end
         S_INS: begin
            rd_idx           = idx_ff - SW'(1);
            sort_ctrl.wr_en  = 1'b1;
            sort_ctrl.wr_key = !((idx_ff != '0) && cmp.gt);
         end
         S_MED_A: rd_idx = med_idx;
         S_MED_B: rd_idx = med_hi_idx;
         default: ;
      endcase
   end

   rmf_sort_store #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_sort_store (
      .clock   (clock),
      .rd_idx  (rd_idx),
      .wr_idx  (wr_idx),
      .ctrl    (sort_ctrl),
      .key     (key),
      .rd_data (rd_data),
      .cmp     (cmp)
   );

   always_ff @(posedge clock) begin
      if (state_ff == S_HIST_WR) begin
         hist[last_ff] <= sample_ff;
      end
      hist_q_ff <= hist[ev_slot_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         window_size_ff <= WINDOW_SIZE_RESET;
         last_ff        <= '0;
         len_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            window_size_ff <= csr_if.window_size;
         end
         // A response taken while the next one is being loaded is replaced, not cleared.
         if (rsp_valid_ff && rsp_if.ready && (state_ff != S_FIN)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  sample_ff  <= req_if.sample;
                  evict_ff   <= CW'(cnt_inc - new_cnt);
                  ev_slot_ff <= ev_start;
                  state_ff   <= S_EV_CHECK;
               end
            end
            S_EV_CHECK: begin
               idx_ff   <= '0;
               found_ff <= 1'b0;
               state_ff <= (evict_ff == '0) ? S_HIST_WR : S_EV_PASS;
            end
            S_EV_PASS: begin
               if (!found_ff && cmp.eq) begin
                  found_ff <= 1'b1;
               end
               if (CW'(idx_ff) == len_ff - CW'(1)) begin
                  len_ff     <= len_ff - CW'(1);
                  evict_ff   <= evict_ff - CW'(1);
                  ev_slot_ff <= (ev_slot_ff == SW'(MAX_WINDOW - 1)) ? '0
                                                                   : ev_slot_ff + SW'(1);
                  state_ff   <= S_EV_CHECK;
               end else begin
                  idx_ff <= idx_ff + SW'(1);
               end
            end
            S_HIST_WR: begin
               last_ff  <= (last_ff == SW'(MAX_WINDOW - 1)) ? '0 : last_ff + SW'(1);
               idx_ff   <= SW'(len_ff);
               state_ff <= S_INS;
            end
            S_INS: begin
               if ((idx_ff != '0) && cmp.gt) begin
                  idx_ff <= idx_ff - SW'(1);
               end else begin
                  len_ff   <= len_ff + CW'(1);
                  state_ff <= S_MED_A;
               end
            end
            S_MED_A: begin
               if (len_ff[0]) begin
                  acc_ff   <= {rd_data, 1'b0};
                  state_ff <= S_FIN;
               end else begin
                  acc_ff   <= {rd_data[SAMPLE_W-1], rd_data};
                  state_ff <= S_MED_B;
               end
            end
            S_MED_B: begin
               // The sum halved by dropping its low bit is the floored mean.
               acc_ff   <= acc_ff + {rd_data[SAMPLE_W-1], rd_data};
               state_ff <= S_FIN;
            end
            S_FIN: begin
               if (!rsp_valid_ff || rsp_if.ready) begin
                  rsp_median_ff <= acc_ff[SAMPLE_W:1];
                  rsp_count_ff  <= COUNT_W'(len_ff);
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[sv/rmf_checker.sv]
// Port-level checks for the running median filter, bound to the top level.
module rmf_checker import rmf_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [SAMPLE_W-1:0] rsp_median_value,
   input logic [COUNT_W-1:0]         rsp_fill_count
);

   // A request is worked on alone, so the block is busy right after taking one.
   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a request is in work");

   a_fill_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_fill_count != '0)
      else $error("response reports an empty window");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_median_value)
         && $stable(rsp_fill_count))
      else $error("stalled response changed");

   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

endmodule

bind running_median_filter_unit rmf_checker u_rmf_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_median_value (rsp_if.median_value),
   .rsp_fill_count   (rsp_if.fill_count)
);
